// ===== rtl/spp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_pkg
// Shared constants and types of the stepper shortest-path positioner.
// ----------------------------------------------------------------------------
package spp_pkg;

  localparam int RING_STEPS = 200;
  localparam int HALF_STEPS = RING_STEPS / 2;
  localparam int POS_W      = 8;
  localparam int STEP_W     = 7;
  localparam int COIL_W     = 4;
  localparam int PERIOD_W   = 16;

  localparam logic [POS_W-1:0]    RING_POS     = POS_W'(RING_STEPS);
  localparam logic [POS_W-1:0]    HALF_POS     = POS_W'(HALF_STEPS);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(10);
  localparam logic [COIL_W-1:0]   COIL_CW_START  = 4'h8;
  localparam logic [COIL_W-1:0]   COIL_CCW_START = 4'h1;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_MOVE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic              cw;
    logic [STEP_W-1:0] steps;
    logic [POS_W-1:0]  pos;
    logic              same;
  } plan_t;

  typedef struct packed {
    logic [COIL_W-1:0] coil;
    logic              busy;
    logic [POS_W-1:0]  pos;
    logic              cw;
    logic              rejected;
  } result_t;

  function automatic logic [COIL_W-1:0] next_coil(input logic [COIL_W-1:0] c,
                                                  input logic cw);
    logic [COIL_W-1:0] n;
    case (c)
      4'h1, 4'h2, 4'h4, 4'h8: begin
        n = cw ? {c[0], c[COIL_W-1:1]} : {c[COIL_W-2:0], c[COIL_W-1]};
      end
      default: begin
        n = cw ? COIL_CW_START : COIL_CCW_START;
      end
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/stepper_shortest_path_positioner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_shortest_path_positioner
// Four-coil stepper positioner on a ring, shortest-way moves, tick-driven.
//
//   port group  direction  contents
//   in_         input      in_opcode, in_target_step; in_valid / in_stall
//   out_        output     coil, busy, position, direction, reject flags
//   cfg_        input      cfg_we, cfg_wdata (step_period)
//
// One word per cycle while in_stall is low; each word is held in the input
// register, and its result is written to the output register as it leaves.
// Motion state updates when a word leaves the input register.
// in_stall rises only when the output register is full and out_stall holds.
// Synchronous active-low reset; step_period resets to 10.
// ----------------------------------------------------------------------------
module stepper_shortest_path_positioner (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic [spp_pkg::POS_W-1:0]    in_target_step,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [spp_pkg::COIL_W-1:0]   out_coil_drive,
  output logic                         out_busy_res,
  output logic [spp_pkg::POS_W-1:0]    out_ring_position,
  output logic                         out_turning_clockwise,
  output logic                         out_move_rejected,
  input  logic                         cfg_we,
  input  logic [spp_pkg::PERIOD_W-1:0] cfg_wdata
);

  logic                         in_valid_r;
  logic                         in_opcode_r;
  logic [spp_pkg::POS_W-1:0]    in_target_r;
  logic                         out_valid_r;
  spp_pkg::result_t             out_res_r;
  spp_pkg::result_t             res;
  logic [spp_pkg::PERIOD_W-1:0] period_r;
  logic                         advance;
  logic                         apply;

  assign advance  = !out_valid_r || !out_stall;
  assign apply    = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  spp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .apply       (apply),
    .opcode      (spp_pkg::opcode_t'(in_opcode_r)),
    .target_step (in_target_r),
    .step_period (period_r),
    .result      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      period_r    <= spp_pkg::PERIOD_RESET;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_opcode_r <= in_opcode;
      in_target_r <= in_target_step;
    end
    if (apply) begin
      out_res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_coil_drive        = out_res_r.coil;
  assign out_busy_res          = out_res_r.busy;
  assign out_ring_position     = out_res_r.pos;
  assign out_turning_clockwise = out_res_r.cw;
  assign out_move_rejected     = out_res_r.rejected;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_res_r))
    else $error("stalled result word changed");
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall) else $error("input stalled with room");
  a_reject_is_move: assert property (@(posedge clk) disable iff (!rst_n)
    apply && res.rejected |-> in_opcode_r) else $error("tick word flagged rejected");
`endif

endmodule

// ===== rtl/spp_move_plan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_move_plan
// Picks the shorter way round the ring and the step count for a move.
// ----------------------------------------------------------------------------
module spp_move_plan (
  input  logic [spp_pkg::POS_W-1:0] target_step,
  input  logic [spp_pkg::POS_W-1:0] position,
  output spp_pkg::plan_t            plan
);

  logic [spp_pkg::POS_W-1:0] tgt;
  logic [spp_pkg::POS_W-1:0] fwd;
  logic [spp_pkg::POS_W-1:0] bwd;
  logic [spp_pkg::POS_W-1:0] fwd_wrap;
  logic [spp_pkg::POS_W-1:0] bwd_wrap;

  always_comb begin
    tgt = (target_step >= spp_pkg::RING_POS) ? target_step - spp_pkg::RING_POS
                                             : target_step;
    fwd      = tgt - position;
    bwd      = position - tgt;
    fwd_wrap = spp_pkg::RING_POS - fwd;
    bwd_wrap = spp_pkg::RING_POS - bwd;
    plan.pos  = tgt;
    plan.same = (tgt == position);
    if (tgt > position) begin
      if (fwd <= spp_pkg::HALF_POS) begin
        plan.cw    = 1'b0;
        plan.steps = fwd[spp_pkg::STEP_W-1:0];
      end else begin
        plan.cw    = 1'b1;
        plan.steps = fwd_wrap[spp_pkg::STEP_W-1:0];
      end
    end else begin
      if (bwd < spp_pkg::HALF_POS) begin
        plan.cw    = 1'b1;
        plan.steps = bwd[spp_pkg::STEP_W-1:0];
      end else begin
        plan.cw    = 1'b0;
        plan.steps = bwd_wrap[spp_pkg::STEP_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/spp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_core
// Motion state, tick handling and the result of each applied word.
// ----------------------------------------------------------------------------
module spp_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         apply,
  input  spp_pkg::opcode_t             opcode,
  input  logic [spp_pkg::POS_W-1:0]    target_step,
  input  logic [spp_pkg::PERIOD_W-1:0] step_period,
  output spp_pkg::result_t             result
);

  logic [spp_pkg::POS_W-1:0]    pos_r,   pos_nxt;
  logic [spp_pkg::COIL_W-1:0]   coil_r,  coil_nxt;
  logic [spp_pkg::STEP_W-1:0]   steps_r, steps_nxt;
  logic                         cw_r,    cw_nxt;
  logic [spp_pkg::PERIOD_W-1:0] hold_r,  hold_nxt;
  logic                         busy;
  logic                         rejected;
  logic [spp_pkg::PERIOD_W-1:0] period_eff;
  spp_pkg::plan_t               plan;

  spp_move_plan u_plan (
    .target_step (target_step),
    .position    (pos_r),
    .plan        (plan)
  );

  always_comb begin
    busy       = (steps_r != '0) || (hold_r != '0);
    period_eff = (step_period == '0) ? spp_pkg::PERIOD_W'(1) : step_period;
    pos_nxt    = pos_r;
    coil_nxt   = coil_r;
    steps_nxt  = steps_r;
    cw_nxt     = cw_r;
    hold_nxt   = hold_r;
    rejected   = 1'b0;
    case (opcode)
      spp_pkg::OP_MOVE: begin
        if (busy) begin
          rejected = 1'b1;
        end else begin
          pos_nxt = plan.pos;
          if (!plan.same) begin
            cw_nxt    = plan.cw;
            steps_nxt = plan.steps;
          end
        end
      end
      spp_pkg::OP_TICK: begin
        if (hold_r == '0 && steps_r != '0) begin
          coil_nxt  = spp_pkg::next_coil(coil_r, cw_r);
          steps_nxt = steps_r - 1'b1;
          hold_nxt  = period_eff - 1'b1;
        end else if (hold_r != '0) begin
          hold_nxt = hold_r - 1'b1;
        end
      end
      default: begin
        rejected = 1'b0;
      end
    endcase
    result.coil     = coil_nxt;
    result.busy     = (steps_nxt != '0) || (hold_nxt != '0);
    result.pos      = pos_nxt;
    result.cw       = cw_nxt;
    result.rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      coil_r  <= '0;
      steps_r <= '0;
      cw_r    <= 1'b0;
      hold_r  <= '0;
    end else if (apply) begin
      pos_r   <= pos_nxt;
      coil_r  <= coil_nxt;
      steps_r <= steps_nxt;
      cw_r    <= cw_nxt;
      hold_r  <= hold_nxt;
    end
  end

`ifndef SYNTHESIS
  a_coil_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(coil_r)) else $error("coil pattern not one-hot");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < spp_pkg::RING_POS) else $error("position off the ring");
  a_steps_half: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= spp_pkg::HALF_POS[spp_pkg::STEP_W-1:0]) else $error("move longer than half turn");
  a_hold_only_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
    !apply |=> $stable(coil_r) && $stable(steps_r) && $stable(hold_r))
    else $error("motion state changed without a word");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stepper shortest-path positioner. A queue of
// tick and move words, directed first and then random, feeds a bursty
// driver. A shadow of the positioner predicts the coil, busy, position,
// direction and reject flags of every accepted word. A stalling monitor
// compares each result word with the oldest prediction. The step period
// is rewritten between phases, down to zero and up to its largest value.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    spp_pkg::opcode_t          op;
    logic [spp_pkg::POS_W-1:0] target;
  } cmd_word_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic                         in_opcode;
  logic [spp_pkg::POS_W-1:0]    in_target_step;
  logic                         out_valid;
  logic                         out_stall;
  logic [spp_pkg::COIL_W-1:0]   out_coil_drive;
  logic                         out_busy_res;
  logic [spp_pkg::POS_W-1:0]    out_ring_position;
  logic                         out_turning_clockwise;
  logic                         out_move_rejected;
  logic                         cfg_we;
  logic [spp_pkg::PERIOD_W-1:0] cfg_wdata;

  stepper_shortest_path_positioner i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_opcode             (in_opcode),
    .in_target_step        (in_target_step),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_coil_drive        (out_coil_drive),
    .out_busy_res          (out_busy_res),
    .out_ring_position     (out_ring_position),
    .out_turning_clockwise (out_turning_clockwise),
    .out_move_rejected     (out_move_rejected),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // shadow positioner state
  logic [spp_pkg::POS_W-1:0]    ring_pos     = '0;
  logic [spp_pkg::COIL_W-1:0]   coil_now     = '0;
  logic [spp_pkg::STEP_W-1:0]   steps_to_go  = '0;
  logic                         going_cw     = 1'b0;
  logic [spp_pkg::PERIOD_W-1:0] coil_hold    = '0;
  logic [spp_pkg::PERIOD_W-1:0] period_now   = spp_pkg::PERIOD_RESET;

  cmd_word_t          pending_words[$];
  spp_pkg::result_t   results_due[$];
  cmd_word_t          cur_word;
  spp_pkg::result_t   want;
  int        errors       = 0;
  int        burst_left   = 1;
  int        gap_left     = 0;
  int        results_seen = 0;
  int        holdoff_left = 0;
  int        stall_mode   = 0;
  int        pattern_age  = 0;
  int        guess_pos    = 0;

  function automatic logic [spp_pkg::COIL_W-1:0] step_coil(
      input logic [spp_pkg::COIL_W-1:0] c, input logic cw);
    if (c == 4'h1 || c == 4'h2 || c == 4'h4 || c == 4'h8) begin
      return cw ? {c[0], c[spp_pkg::COIL_W-1:1]} : {c[spp_pkg::COIL_W-2:0], c[spp_pkg::COIL_W-1]};
    end
    return cw ? spp_pkg::COIL_CW_START : spp_pkg::COIL_CCW_START;
  endfunction

  task automatic apply_word(input cmd_word_t w);
    int               t;
    int               p;
    int               d;
    logic             rej;
    spp_pkg::result_t r;
    rej = 1'b0;
    if (w.op == spp_pkg::OP_MOVE) begin
      if (steps_to_go != 0 || coil_hold != 0) begin
        rej = 1'b1;
      end else begin
        t = int'(w.target) % spp_pkg::RING_STEPS;
        p = int'(ring_pos);
        if (t > p) begin
          d = t - p;
          going_cw = (d > spp_pkg::HALF_STEPS);
          steps_to_go = spp_pkg::STEP_W'((d > spp_pkg::HALF_STEPS) ?
                                         spp_pkg::RING_STEPS - d : d);
        end else if (t < p) begin
          d = p - t;
          going_cw = (d < spp_pkg::HALF_STEPS);
          steps_to_go = spp_pkg::STEP_W'((d < spp_pkg::HALF_STEPS) ?
                                         d : spp_pkg::RING_STEPS - d);
        end
        ring_pos = spp_pkg::POS_W'(t);
      end
    end else begin
      if (coil_hold == 0 && steps_to_go != 0) begin
        coil_now = step_coil(coil_now, going_cw);
        steps_to_go = steps_to_go - 1'b1;
        coil_hold = (period_now == 0) ? spp_pkg::PERIOD_W'(1) : period_now;
      end
      if (coil_hold != 0) begin
        coil_hold = coil_hold - 1'b1;
      end
    end
    r.coil     = coil_now;
    r.busy     = (steps_to_go != 0 || coil_hold != 0);
    r.pos      = ring_pos;
    r.cw       = going_cw;
    r.rejected = rej;
    results_due.push_back(r);
  endtask

  task automatic check_field(input string fname, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $display("%0t %s: expected %0d, got %0d", $time, fname, exp_val, got_val);
      errors++;
    end
  endtask

  // driver: bursts of words with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_word(cur_word);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          cur_word = pending_words.pop_front();
          in_valid       <= 1'b1;
          in_opcode      <= cur_word.op;
          in_target_step <= cur_word.target;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare and stall on a pattern of its own
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t result word: expected none, got coil %h pos %0d", $time,
                   out_coil_drive, out_ring_position);
          errors++;
        end else begin
          want = results_due.pop_front();
          check_field("coil_drive", want.coil, out_coil_drive);
          check_field("busy_res", want.busy, out_busy_res);
          check_field("ring_position", want.pos, out_ring_position);
          check_field("turning_clockwise", want.cw, out_turning_clockwise);
          check_field("move_rejected", want.rejected, out_move_rejected);
        end
        results_seen++;
        // long hold-off so the block fills up and stalls its input
        if (results_seen == 400 || results_seen == 1300) begin
          holdoff_left = 80;
        end
      end
      pattern_age++;
      if (pattern_age == 50) begin
        pattern_age = 0;
        stall_mode = $urandom_range(3);
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(3) == 0);
          2: out_stall <= ($urandom_range(1) == 0);
          default: out_stall <= ($urandom_range(7) != 0);
        endcase
      end
    end
  end

  task automatic push_word(input spp_pkg::opcode_t op, input int tgt);
    cmd_word_t w;
    w.op = op;
    w.target = spp_pkg::POS_W'(tgt);
    pending_words.push_back(w);
  endtask

  task automatic queue_random(input int n);
    int tgt;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 10) begin
        case ($urandom_range(9))
          0, 1, 2, 3: tgt = $urandom_range(spp_pkg::RING_STEPS - 1);
          4, 5, 6: tgt = (guess_pos + spp_pkg::RING_STEPS + $urandom_range(12) - 6) %
                         spp_pkg::RING_STEPS;
          7: tgt = (guess_pos + spp_pkg::HALF_STEPS) % spp_pkg::RING_STEPS;
          8: tgt = (guess_pos + spp_pkg::HALF_STEPS - 1 + $urandom_range(2)) %
                   spp_pkg::RING_STEPS;
          default: tgt = $urandom_range(255, spp_pkg::RING_STEPS);
        endcase
        guess_pos = tgt % spp_pkg::RING_STEPS;
        push_word(spp_pkg::OP_MOVE, tgt);
      end else begin
        push_word(spp_pkg::OP_TICK, $urandom_range(255));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || results_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_period(input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= spp_pkg::PERIOD_W'(value);
    @(posedge clk);
    cfg_we     <= 1'b0;
    period_now = spp_pkg::PERIOD_W'(value);
  endtask

  task automatic run_phase(input int value, input int n);
    wait_drained();
    write_period(value);
    @(negedge clk);
    queue_random(n);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = spp_pkg::OP_TICK;
    in_target_step = '0;
    out_stall      = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: idle tick, move to present position, move while busy,
    // exact hold at the reset period, target outside the ring
    push_word(spp_pkg::OP_TICK, 0);
    push_word(spp_pkg::OP_MOVE, 0);
    push_word(spp_pkg::OP_TICK, 255);
    push_word(spp_pkg::OP_MOVE, 1);
    push_word(spp_pkg::OP_MOVE, 199);
    repeat (10) push_word(spp_pkg::OP_TICK, $urandom_range(255));
    push_word(spp_pkg::OP_MOVE, 199);
    push_word(spp_pkg::OP_TICK, 0);
    push_word(spp_pkg::OP_MOVE, 255);
    repeat (3) push_word(spp_pkg::OP_TICK, 0);
    guess_pos = 199;
    run_phase(1, 500);
    run_phase(2, 450);
    run_phase(3, 400);
    run_phase(0, 200);
    run_phase(7, 150);
    run_phase(65535, 50);
    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("stepper_shortest_path_positioner: match");
    end else begin
      $display("stepper_shortest_path_positioner: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("stepper_shortest_path_positioner: mismatch");
    $finish;
  end

endmodule
